FILE: rtl/core/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types, constants and helpers of the caseless matcher
// Holds the sizing constants, the queue item layout, the configuration
// bundle and the ASCII case-folding function.
// ----------------------------------------------------------------------------
package csm_pkg;

    // sizing
    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int START_W     = 16;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int HIST_DEPTH  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    // character constants for folding
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } csm_cfg_idx_t;

    // one classified byte travelling from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] folded;
        logic              eol;
        logic [POS_W-1:0]  pos;
    } csm_item_t;

    // pattern configuration seen by the compare logic
    typedef struct packed {
        logic [2*WORD_W-1:0] pattern;
        logic [LEN_W-1:0]    length;
    } csm_cfg_t;

    // fold A..Z onto a..z, all other bytes unchanged
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            r = b + (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front: input stage of the caseless matcher
// Accepts raw text bytes, folds their case and tags each one with its
// saturating offset in the line before handing it to the queue.
// ----------------------------------------------------------------------------
module csm_front
    import csm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_text_byte,
    input  logic              s_end_of_line,
    output logic              push_valid,
    input  logic              push_ready,
    output csm_item_t         push_item
);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;

    // request handshake passes straight to the queue
    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // classify the byte
    always_comb begin
        push_item.folded = fold_byte(s_text_byte);
        push_item.eol    = s_end_of_line;
        push_item.pos    = pos_reg;
    end

    // line offset, saturating, cleared after the last byte
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_end_of_line) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue: two-entry queue between front and back
// Lets the input side keep accepting while the back end waits on the
// result channel.
// ----------------------------------------------------------------------------
module csm_queue
    import csm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  csm_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output csm_item_t pop_item
);

    csm_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back: window compare and result stage of the caseless matcher
// Compares the pattern against the newest byte and the folded history,
// tracks the first match of each line and registers the result.
// ----------------------------------------------------------------------------
module csm_back
    import csm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  csm_cfg_t           cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  csm_item_t          pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_match_here,
    output logic [START_W-1:0] m_match_start,
    output logic               m_line_end,
    output logic               m_line_matched
);

    logic [BYTE_W-1:0]  hist_reg [HIST_DEPTH];
    logic               already_reg;
    logic               already_next;
    logic               out_valid_reg;
    logic               match_here_reg;
    logic [START_W-1:0] match_start_reg;
    logic               line_end_reg;
    logic               line_matched_reg;
    logic               take;
    logic               hit;
    logic               first;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   last;
    logic [POS_W+START_W-1:0] start_ext;

    assign pop_ready = !out_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;

    // window compare over the newest byte and the history
    always_comb begin
        logic [BYTE_W-1:0] win [MAX_PATTERN];
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] wsel;
        logic              len_ok;
        logic              all_eq;
        win[0] = pop_item.folded;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win[k] = hist_reg[k-1];
        end
        last   = cfg.length - 1'b1;
        len_ok = (cfg.length != '0) && (cfg.length <= LEN_W'(MAX_PATTERN))
                 && (({1'b0, pop_item.pos} + 1'b1) >= (POS_W+1)'(cfg.length));
        all_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pbyte = fold_byte(cfg.pattern[BYTE_W*j +: BYTE_W]);
            wsel  = '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (LEN_W'(j + k) == last) begin
                    wsel = win[k];
                end
            end
            if (LEN_W'(j) <= last && pbyte != wsel) begin
                all_eq = 1'b0;
            end
        end
        hit       = len_ok && all_eq;
        start     = pop_item.pos - POS_W'(last);
        start_ext = {{START_W{1'b0}}, start};
        first     = hit && !already_reg;
    end

    // first-match tracking within the line
    always_comb begin
        already_next = already_reg;
        if (take) begin
            already_next = pop_item.eol ? 1'b0 : (already_reg || hit);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            already_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            already_reg <= already_next;
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // folded history shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (take) begin
            hist_reg[0] <= pop_item.folded;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (take) begin
            match_here_reg   <= first;
            match_start_reg  <= first ? start_ext[START_W-1:0] : '0;
            line_end_reg     <= pop_item.eol;
            line_matched_reg <= pop_item.eol && (already_reg || hit);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_match_here   = match_here_reg;
    assign m_match_start  = match_start_reg;
    assign m_line_end     = line_end_reg;
    assign m_line_matched = line_matched_reg;

endmodule

FILE: rtl/core/caseless_substring_matcher.sv
// Path: a byte's result passes through the queue slot and then the back-end
// result register before it is valid.
// Throughput: one byte per cycle while the output is not stalled; the window
// compare against the folded history completes in the single back-end stage.
// A two-entry queue keeps input accepting while the output stalls, until full.
// Reset clears the pattern registers, line offset, match flag and history.
// ----------------------------------------------------------------------------
// caseless_substring_matcher: top level
// Holds the pattern registers and joins front, queue and back end.
// ----------------------------------------------------------------------------
module caseless_substring_matcher
    import csm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_text_byte,
    input  logic                 s_end_of_line,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_match_here,
    output logic [START_W-1:0]   m_match_start,
    output logic                 m_line_end,
    output logic                 m_line_matched
);

    logic [WORD_W-1:0] pat_low_reg;
    logic [WORD_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    csm_cfg_t          cfg;
    logic              push_valid;
    logic              push_ready;
    csm_item_t         push_item;
    logic              pop_valid;
    logic              pop_ready;
    csm_item_t         pop_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_valid) begin
            case (csm_cfg_idx_t'(cfg_index))
                CFG_PATTERN_LOW: begin
                    pat_low_reg <= cfg_data;
                end
                CFG_PATTERN_HIGH: begin
                    pat_high_reg <= cfg_data;
                end
                CFG_PATTERN_LEN: begin
                    pat_len_reg <= cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = pat_len_reg;

    csm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_line (s_end_of_line),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    csm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    csm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_here   (m_match_here),
        .m_match_start  (m_match_start),
        .m_line_end     (m_line_end),
        .m_line_matched (m_line_matched)
    );

endmodule
